>>> src/ptst_pkg.sv
// Package for the periodic timer slot table: command codes, result kinds and
// the structs that pass between the slot cells and the top level.
// No dependencies.
`default_nettype none

package ptst_pkg;

    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned PORT_T_W = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Walk token handed from one cell to the next
    typedef struct packed {
        logic             tok;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_link;

    // Fire request from the cell that holds the token
    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] handle;
    } t_fire;

endpackage

`default_nettype wire

>>> src/ptst_cell.sv
// One timer slot of the chain: holds the slot state, acts on the command when
// the walk token reaches it and hands the token to the next cell.
// Depends on ptst_pkg.
`default_nettype none

module ptst_cell #(
    parameter int INDEX     = 0,
    parameter int TIME_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_adv,
    input  ptst_pkg::t_cmd               i_cmd,
    input  wire  [ptst_pkg::HANDLE_W-1:0] i_handle,
    input  wire  [ptst_pkg::TAG_W-1:0]   i_tag,
    input  wire  [TIME_BITS-1:0]         i_period,
    input  wire  [TIME_BITS-1:0]         i_first,
    input  wire  [TIME_BITS-1:0]         i_life,
    input  wire                          i_forever,
    input  wire  [TIME_BITS-1:0]         i_now,
    input  ptst_pkg::t_link              i_link,
    output ptst_pkg::t_link              o_link,
    output ptst_pkg::t_fire              o_fire
);
    import ptst_pkg::*;

    logic                 r_active;
    logic                 n_active;
    logic [HANDLE_W-1:0]  r_handle;
    logic [TAG_W-1:0]     r_tag;
    logic [TIME_BITS-1:0] r_due;
    logic [TIME_BITS-1:0] n_due;
    logic [TIME_BITS-1:0] r_period;
    logic [TIME_BITS-1:0] r_expire;
    logic                 r_endless;
    t_link                r_link;
    t_link                n_link;
    logic                 wr;
    logic                 fire;
    logic                 act;

    assign act = i_link.tok && i_adv;

    always_comb begin
        n_active = r_active;
        n_due    = r_due;
        n_link   = i_link;
        wr       = 1'b0;
        fire     = 1'b0;
        if (i_link.tok) begin
            unique case (i_cmd)
                CMD_ADD: begin
                    if (!i_link.hit && !r_active) begin
                        wr         = 1'b1;
                        n_active   = 1'b1;
                        n_link.hit = 1'b1;
                        n_link.idx = IDX_W'(INDEX);
                    end
                end
                CMD_REMOVE: begin
                    if (!i_link.hit && r_active && r_tag == i_tag) begin
                        n_active   = 1'b0;
                        n_link.hit = 1'b1;
                        n_link.idx = IDX_W'(INDEX);
                    end
                end
                CMD_CLEAR: begin
                    n_active = 1'b0;
                end
                CMD_TICK: begin
                    if (r_active) begin
                        // expiry wins over firing
                        if (!r_endless && i_now >= r_expire) begin
                            n_active = 1'b0;
                        end else if (i_now >= r_due) begin
                            fire  = 1'b1;
                            n_due = r_due + r_period;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_link.tok <= 1'b0;
        end else begin
            if (act) begin
                r_active <= n_active;
            end
            if (i_adv) begin
                r_link <= n_link;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (act) begin
            if (wr) begin
                r_handle  <= i_handle;
                r_tag     <= i_tag;
                r_due     <= i_first;
                r_period  <= i_period;
                r_endless <= i_forever;
                r_expire  <= i_first + i_life;
            end else begin
                r_due <= n_due;
            end
        end
    end

    assign o_link        = r_link;
    assign o_fire.valid  = fire;
    assign o_fire.idx    = IDX_W'(INDEX);
    assign o_fire.handle = fire ? r_handle : '0;

endmodule

`default_nettype wire

>>> src/periodic_timer_slot_table.sv
// The status result is produced when the walk token leaves the last slot cell;
// fire results appear before it, at most one per slot, in slot order.
// Only one transaction is in flight: the next one is accepted as the walk token
// leaves the last cell. It steps one slot cell per cycle; output stall holds it.
// Reset: synchronous active low; all slots free, no result pending.
`default_nettype none

module periodic_timer_slot_table #(
    parameter int NUM_SLOTS = 8,
    parameter int TIME_BITS = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_command,
    input  wire  [ptst_pkg::HANDLE_W-1:0]  i_job_handle,
    input  wire  [ptst_pkg::TAG_W-1:0]     i_job_tag,
    input  wire  [ptst_pkg::PORT_T_W-1:0]  i_repeat_period,
    input  wire  [ptst_pkg::PORT_T_W-1:0]  i_start_delay,
    input  wire  [ptst_pkg::PORT_T_W-1:0]  i_life_span,
    input  wire                            i_run_forever,
    input  wire  [ptst_pkg::PORT_T_W-1:0]  i_current_time,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_result_kind,
    output logic [ptst_pkg::IDX_W-1:0]     o_slot_index,
    output logic [ptst_pkg::HANDLE_W-1:0]  o_fired_handle,
    output logic                           o_success,
    output logic                           o_last
);
    import ptst_pkg::*;

    t_cmd                 r_cmd;
    logic [HANDLE_W-1:0]  r_handle;
    logic [TAG_W-1:0]     r_tag;
    logic [TIME_BITS-1:0] r_period;
    logic [TIME_BITS-1:0] r_first;
    logic [TIME_BITS-1:0] r_life;
    logic                 r_forever;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_busy;
    logic                 r_head_tok;
    logic                 r_out_valid;
    logic                 r_kind;
    logic [IDX_W-1:0]     r_idx;
    logic [HANDLE_W-1:0]  r_out_handle;
    logic                 r_success;
    logic                 r_last;

    logic                 adv;
    logic                 accept;
    logic                 done;
    t_link                links [NUM_SLOTS+1];
    t_fire                fires [NUM_SLOTS];
    t_fire                fire_any;
    t_link                tail;

    assign adv    = !r_out_valid || !i_out_stall;
    assign tail   = links[NUM_SLOTS];
    assign done   = tail.tok && adv;
    assign o_in_stall = r_busy && !done;
    assign accept = i_in_valid && !o_in_stall;

    assign links[0] = '{tok: r_head_tok, hit: 1'b0, idx: '0};

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        ptst_cell #(
            .INDEX    (g),
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cmd   (r_cmd),
            .i_handle(r_handle),
            .i_tag   (r_tag),
            .i_period(r_period),
            .i_first (r_first),
            .i_life  (r_life),
            .i_forever(r_forever),
            .i_now   (r_now),
            .i_link  (links[g]),
            .o_link  (links[g+1]),
            .o_fire  (fires[g])
        );
    end

    // Only the token holder can fire, so OR the requests together
    always_comb begin
        fire_any = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            fire_any.valid  = fire_any.valid | fires[k].valid;
            fire_any.idx    = fire_any.idx | (fires[k].valid ? fires[k].idx : '0);
            fire_any.handle = fire_any.handle | fires[k].handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_head_tok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy     <= 1'b1;
                r_head_tok <= 1'b1;
            end else begin
                if (done) begin
                    r_busy <= 1'b0;
                end
                if (adv) begin
                    r_head_tok <= 1'b0;
                end
            end
            if (adv) begin
                r_out_valid <= fire_any.valid || tail.tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= t_cmd'(i_command);
            r_handle  <= i_job_handle;
            r_tag     <= i_job_tag;
            r_period  <= TIME_BITS'(i_repeat_period);
            r_first   <= TIME_BITS'(i_current_time) + TIME_BITS'(i_start_delay);
            r_life    <= TIME_BITS'(i_life_span);
            r_forever <= i_run_forever;
            r_now     <= TIME_BITS'(i_current_time);
        end
        if (adv) begin
            if (tail.tok) begin
                r_kind       <= KIND_STATUS;
                r_idx        <= tail.idx;
                r_out_handle <= '0;
                r_success    <= (r_cmd == CMD_CLEAR || r_cmd == CMD_TICK) ? 1'b1 : tail.hit;
                r_last       <= 1'b1;
            end else begin
                r_kind       <= KIND_FIRE;
                r_idx        <= fire_any.idx;
                r_out_handle <= fire_any.handle;
                r_success    <= 1'b0;
                r_last       <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_slot_index   = r_idx;
    assign o_fired_handle = r_out_handle;
    assign o_success      = r_success;
    assign o_last         = r_last;

endmodule

`default_nettype wire

>>> src/ptst_checker.sv
// Port-level checker for the periodic timer slot table, bound to the top level.
// Depends on ptst_pkg and periodic_timer_slot_table.
`default_nettype none

module ptst_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           o_in_stall,
    input wire                           o_out_valid,
    input wire                           i_out_stall,
    input wire                           o_result_kind,
    input wire [ptst_pkg::IDX_W-1:0]     o_slot_index,
    input wire [ptst_pkg::HANDLE_W-1:0]  o_fired_handle,
    input wire                           o_success,
    input wire                           o_last
);
    import ptst_pkg::*;

    // A held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_slot_index) && $stable(o_fired_handle) && $stable(o_last))
        else $error("stalled result changed");

    // One transaction at a time: stall follows every acceptance
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted during walk");

    // Only the status result closes a transaction
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_result_kind == KIND_STATUS)))
        else $error("last flag disagrees with result kind");

    // Fire results never report success, status results carry no handle
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_result_kind == KIND_FIRE && !o_success)
            || (o_result_kind == KIND_STATUS && o_fired_handle == '0)))
        else $error("result fields inconsistent with kind");

endmodule

bind periodic_timer_slot_table ptst_checker u_ptst_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for periodic_timer_slot_table: directed and random commands
// are checked against an in-bench slot table model held in a small scoreboard class.
// Depends on ptst_pkg and the periodic_timer_slot_table RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptst_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD = 250;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    slot;
        logic [HANDLE_W-1:0] handle;
        logic                ok;
        logic                last;
    } t_result;

    // Slot table model and queue of results still owed by the block
    class slot_table_scoreboard;
        localparam int SLOTS = 8;

        bit              active[SLOTS];
        bit [15:0]       held_handle[SLOTS];
        bit [31:0]       held_tag[SLOTS];
        bit [31:0]       due_at[SLOTS];
        bit [31:0]       period_of[SLOTS];
        bit [31:0]       expiry_at[SLOTS];
        bit              endless[SLOTS];
        t_result         owed[$];
        int              errors;
        int              fires_checked;
        int              status_checked;
        int              cmd_count[4];

        function void owe(logic kind, int slot, logic [15:0] handle, logic ok, logic last);
            t_result r;
            r.kind = kind;
            r.slot = IDX_W'(slot);
            r.handle = handle;
            r.ok = ok;
            r.last = last;
            owed.push_back(r);
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function void note_command(t_cmd cmd, logic [15:0] handle, logic [31:0] tag,
                                   logic [31:0] period, logic [31:0] delay,
                                   logic [31:0] life, logic forever_flag,
                                   logic [31:0] now);
            int slot;
            bit [31:0] first_due;
            slot = -1;
            cmd_count[int'(cmd)]++;
            case (cmd)
                CMD_ADD: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!active[i] && slot < 0) slot = i;
                    if (slot >= 0) begin
                        first_due = now + delay;
                        active[slot] = 1;
                        held_handle[slot] = handle;
                        held_tag[slot] = tag;
                        due_at[slot] = first_due;
                        period_of[slot] = period;
                        endless[slot] = forever_flag;
                        expiry_at[slot] = forever_flag ? 32'd0 : first_due + life;
                        owe(KIND_STATUS, slot, 16'd0, 1'b1, 1'b1);
                    end else begin
                        owe(KIND_STATUS, 0, 16'd0, 1'b0, 1'b1);
                    end
                end
                CMD_REMOVE: begin
                    // only live slots may match a tag
                    for (int i = 0; i < SLOTS; i++)
                        if (active[i] && held_tag[i] == tag && slot < 0) slot = i;
                    if (slot >= 0) begin
                        active[slot] = 0;
                        owe(KIND_STATUS, slot, 16'd0, 1'b1, 1'b1);
                    end else begin
                        owe(KIND_STATUS, 0, 16'd0, 1'b0, 1'b1);
                    end
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < SLOTS; i++) active[i] = 0;
                    owe(KIND_STATUS, 0, 16'd0, 1'b1, 1'b1);
                end
                default: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (active[i]) begin
                            // an expired slot is dropped silently, even when due
                            if (!endless[i] && now >= expiry_at[i]) begin
                                active[i] = 0;
                            end else if (now >= due_at[i]) begin
                                owe(KIND_FIRE, i, held_handle[i], 1'b0, 1'b0);
                                due_at[i] = due_at[i] + period_of[i];
                            end
                        end
                    end
                    owe(KIND_STATUS, 0, 16'd0, 1'b1, 1'b1);
                end
            endcase
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind %0d slot %0d handle 0x%0h",
                         $time, got.kind, got.slot, got.handle);
                return;
            end
            want = owed.pop_front();
            if (want.kind == KIND_FIRE) fires_checked++;
            else status_checked++;
            compare("result_kind", want.kind, got.kind);
            compare("slot_index", want.slot, got.slot);
            compare("fired_handle", want.handle, got.handle);
            compare("success", want.ok, got.ok);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_command;
    logic [HANDLE_W-1:0] i_job_handle;
    logic [TAG_W-1:0]    i_job_tag;
    logic [31:0]         i_repeat_period;
    logic [31:0]         i_start_delay;
    logic [31:0]         i_life_span;
    logic                i_run_forever;
    logic [31:0]         i_current_time;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_result_kind;
    logic [IDX_W-1:0]    o_slot_index;
    logic [HANDLE_W-1:0] o_fired_handle;
    logic                o_success;
    logic                o_last;

    slot_table_scoreboard board;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          want_hold;
    bit          hold_done;
    int          hold_left;
    int          quiet_cycles;
    bit [31:0]   clock_ms;
    bit [31:0]   live_tags[$];

    periodic_timer_slot_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_job_handle    (i_job_handle),
        .i_job_tag       (i_job_tag),
        .i_repeat_period (i_repeat_period),
        .i_start_delay   (i_start_delay),
        .i_life_span     (i_life_span),
        .i_run_forever   (i_run_forever),
        .i_current_time  (i_current_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_slot_index    (o_slot_index),
        .o_fired_handle  (o_fired_handle),
        .o_success       (o_success),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random stall, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (want_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result('{o_result_kind, o_slot_index, o_fired_handle,
                                 o_success, o_last});
    end

    // Watchdog: count cycles in which neither channel moves a transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(input t_cmd cmd, input logic [15:0] handle,
                            input logic [31:0] tag, input logic [31:0] period,
                            input logic [31:0] delay, input logic [31:0] life,
                            input logic forever_flag, input logic [31:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command = cmd;
        i_job_handle = handle;
        i_job_tag = tag;
        i_repeat_period = period;
        i_start_delay = delay;
        i_life_span = life;
        i_run_forever = forever_flag;
        i_current_time = now;
        do @(posedge i_clk); while (o_in_stall);
        board.note_command(cmd, handle, tag, period, delay, life, forever_flag, now);
        @(negedge i_clk);
    endtask

    task automatic send_tick(input logic [31:0] now);
        send_cmd(CMD_TICK, 16'($urandom()), $urandom(), $urandom(), $urandom(),
                 $urandom(), 1'($urandom()), now);
    endtask

    task automatic send_remove(input logic [31:0] tag);
        send_cmd(CMD_REMOVE, 16'($urandom()), tag, $urandom(), $urandom(),
                 $urandom(), 1'($urandom()), $urandom());
    endtask

    task automatic send_clear();
        send_cmd(CMD_CLEAR, 16'($urandom()), $urandom(), $urandom(), $urandom(),
                 $urandom(), 1'($urandom()), $urandom());
    endtask

    // Mostly well-formed schedules on a running clock, with some noise
    task automatic random_item();
        int pick;
        bit [31:0] tag;
        pick = $urandom_range(99);
        if (pick < 30) begin
            tag = $urandom();
            live_tags.push_back(tag);
            if (live_tags.size() > 16) void'(live_tags.pop_front());
            send_cmd(CMD_ADD, 16'($urandom()), tag,
                     ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 8),
                     $urandom_range(0, 10), $urandom_range(0, 60),
                     ($urandom_range(2) == 0), clock_ms);
        end else if (pick < 75) begin
            clock_ms += $urandom_range(0, 4);
            send_tick(clock_ms);
        end else if (pick < 90) begin
            if (live_tags.size() > 0 && $urandom_range(9) < 8)
                tag = live_tags[$urandom_range(live_tags.size() - 1)];
            else
                tag = $urandom();
            send_remove(tag);
        end else if (pick < 93) begin
            send_clear();
        end else begin
            send_cmd(t_cmd'($urandom_range(3)), 16'($urandom()), $urandom(), $urandom(),
                     $urandom(), $urandom(), 1'($urandom()), $urandom());
        end
    endtask

    initial begin
        board = new();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        want_hold = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = CMD_TICK;
        i_job_handle = '0;
        i_job_tag = '0;
        i_repeat_period = '0;
        i_start_delay = '0;
        i_life_span = '0;
        i_run_forever = 1'b0;
        i_current_time = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, field extremes, full table, duplicate tags, wrap
        tx_idle_pct = 24;
        rx_idle_pct = 88;
        send_tick(32'd0);
        send_remove(32'hFFFF_FFFF);
        send_cmd(CMD_ADD, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
        send_cmd(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD, 16'h1234, 32'hA5A5_A5A5, 32'd10, 32'd5, 32'd100, 1'b0, 32'd0);
        // expiry wraps below the first due time
        send_cmd(CMD_ADD, 16'h5A5A, 32'hA5A5_A5A5, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0,
                 32'h10);
        send_cmd(CMD_ADD, 16'hBEEF, 32'd7, 32'hFFFF_FFFF, 32'd3, 32'd50, 1'b1, 32'd0);
        repeat (3)
            send_cmd(CMD_ADD, 16'($urandom()), $urandom(), $urandom(), 32'h7000_0000,
                     $urandom(), 1'b1, 32'd0);
        send_cmd(CMD_ADD, 16'h7777, 32'h1111_2222, 32'd1, 32'd1, 32'd1, 1'b0, 32'd0);
        send_tick(32'd0);
        send_tick(32'd5);
        send_remove(32'hA5A5_A5A5);
        send_remove(32'hA5A5_A5A5);
        send_remove(32'hA5A5_A5A5);
        send_cmd(CMD_ADD, 16'h4321, 32'hA5A5_A5A5, 32'd2, 32'd0, 32'd8, 1'b0, 32'd6);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd7);
        send_clear();
        send_tick(32'h8000_0000);
        send_remove(32'h0);

        // Random: three idling phases, the last one starting just below time wrap
        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            tx_idle_pct = (phase_no == 0) ? 24 : (phase_no == 1) ? 88 : 0;
            rx_idle_pct = (phase_no == 0) ? 88 : (phase_no == 1) ? 24 : 0;
            clock_ms = (phase_no == 2) ? 32'hFFFF_FFC0 : $urandom();
            send_clear();
            for (int n = 0; n < 42; n++) begin
                if (phase_no == 2 && n == 5) want_hold = 1'b1;
                random_item();
            end
        end
        i_in_valid = 1'b0;

        while (board.outstanding() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d add, %0d remove, %0d clear and %0d tick transactions;",
                 board.cmd_count[CMD_ADD], board.cmd_count[CMD_REMOVE],
                 board.cmd_count[CMD_CLEAR], board.cmd_count[CMD_TICK]);
        $display("checked %0d fire and %0d status results, %0d errors",
                 board.fires_checked, board.status_checked, board.errors);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial quiet_cycles = 0;

endmodule

`default_nettype wire
